// ===== rtl/core/multiturn_encoder_to_steps_core_assert.svh =====
// Assertion macros for the multi-turn encoder core.
// Included by modules that carry concurrent checks; no dependencies.
`ifndef MULTITURN_ENCODER_TO_STEPS_CORE_ASSERT_SVH
`define MULTITURN_ENCODER_TO_STEPS_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define MTES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mtes assertion failed");
`define MTES_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mtes assertion failed");
`else
`define MTES_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MTES_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/mtes_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the multi-turn encoder core.
// No dependencies.
package mtes_pkg;

	localparam int ANGLE_W  = 12;
	localparam int TURN_W   = 24;
	localparam int STEPS_W  = 48;
	localparam int MSTEP_W  = 9;
	localparam int POS_W    = TURN_W + ANGLE_W;
	localparam int PROD1_W  = POS_W + MSTEP_W + 1;
	localparam int PROD2_W  = PROD1_W + 8;
	localparam int QUOT_W   = PROD2_W - ANGLE_W;
	localparam int DIFF_W   = STEPS_W + 1;

	localparam logic [3:0]                ANGLE_HI_MASK    = 4'hF;
	localparam logic signed [ANGLE_W:0]   HALF_TURN_COUNTS = 13'sd2048;
	localparam logic signed [PROD2_W-1:0] MOTOR_STEPS      = 54'sd200;
	localparam logic signed [PROD2_W-1:0] DIV_BIAS         = 54'sd4095;
	localparam logic signed [TURN_W-1:0]  TURN_MAX         = 24'sh7FFFFF;
	localparam logic signed [TURN_W-1:0]  TURN_MIN         = 24'sh800000;
	localparam logic signed [STEPS_W-1:0] STEPS_MAX        = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [STEPS_W-1:0] STEPS_MIN        = 48'sh8000_0000_0000;
	localparam logic [MSTEP_W-1:0]        MSTEP_RESET      = 9'd8;

	localparam logic REG_MICROSTEPS = 1'b0;
	localparam logic REG_OFFSET     = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MUL   = 4'b0010,
		ST_SCALE = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	typedef struct packed {
		logic capture;
		logic mul;
		logic scale;
		logic load_out;
	} cmd_t;

endpackage

// ===== rtl/core/multiturn_encoder_to_steps_core.sv =====
`timescale 1ns / 1ps
// Top level of the multi-turn encoder to motor step core.
// Depends on mtes_pkg, mtes_ctrl and mtes_dp.
//
// Slave stream: one transaction per angle reading, tdata = high byte, low byte.
// Master stream: one transaction per reading with the microstep position, the
// turn count and the assembled angle.
// Config channel: cfg_index 0 writes microsteps per step, 1 writes the signed
// position offset; cfg_ready is always high. Write only while idle.
// After the input transaction the reading passes the multiply, scale and finish
// states, and m_tvalid rises when the finish state loads the output register.
// A new reading is taken only back in the idle state, as the capture, multiply,
// scale and finish steps of the sequencer share one datapath.
// A finished result waits in the output register; while the receiver stalls
// the next reading is still taken and worked up to the finish step, where it
// holds until the waiting result is taken.
// Reset clears the turn counter and previous angle, marks the next reading as
// the first (turn count forced to zero) and restores the register defaults.
module multiturn_encoder_to_steps_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] angle_high_byte, [15:8] angle_low_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // [47:0] motor_steps, [71:48] turn_count,
	                               // [83:72] raw_angle, [87:84] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [47:0] cfg_data
);

	mtes_pkg::cmd_t                       cmd;
	logic signed [mtes_pkg::STEPS_W-1:0]  motor_steps;
	logic signed [mtes_pkg::TURN_W-1:0]   turn_count;
	logic [mtes_pkg::ANGLE_W-1:0]         raw_angle;

	assign cfg_ready = 1'b1;

	mtes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	mtes_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.angle_high_byte (s_tdata[7:0]),
		.angle_low_byte  (s_tdata[15:8]),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.motor_steps     (motor_steps),
		.turn_count      (turn_count),
		.raw_angle       (raw_angle)
	);

	assign m_tdata = {4'b0000, raw_angle, turn_count, motor_steps};

endmodule

// ===== rtl/core/mtes_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the multi-turn encoder core: handshakes and datapath commands.
// Depends on mtes_pkg and the assertion macro header.
`include "multiturn_encoder_to_steps_core_assert.svh"
module mtes_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output mtes_pkg::cmd_t cmd
);

	mtes_pkg::state_t state_q, state_d;
	logic             m_tvalid_q;
	logic             accept;

	assign s_tready = (state_q == mtes_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.capture  = accept;
		case (state_q)
			mtes_pkg::ST_IDLE: begin
				if (accept) state_d = mtes_pkg::ST_MUL;
			end
			mtes_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = mtes_pkg::ST_SCALE;
			end
			mtes_pkg::ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = mtes_pkg::ST_FIN;
			end
			mtes_pkg::ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = mtes_pkg::ST_IDLE;
				end
			end
			default: state_d = mtes_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mtes_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	`MTES_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.load_out && m_tvalid_q, m_tready)
	`MTES_ASSERT_NXT(a_accept_to_fin, clk, arst_n, accept, ##2 (state_q == mtes_pkg::ST_FIN))
	`MTES_ASSERT_NXT(a_fin_stall, clk, arst_n,
		(state_q == mtes_pkg::ST_FIN) && m_tvalid_q && !m_tready,
		(state_q == mtes_pkg::ST_FIN))

endmodule

// ===== rtl/core/mtes_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the multi-turn encoder core: turn tracking, scaling, offset.
// Depends on mtes_pkg; driven by commands from mtes_ctrl.
module mtes_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mtes_pkg::cmd_t                        cmd,
	input  logic [7:0]                            angle_high_byte,
	input  logic [7:0]                            angle_low_byte,
	input  logic                                  cfg_we,
	input  logic                                  cfg_index,
	input  logic [mtes_pkg::STEPS_W-1:0]          cfg_data,
	output logic signed [mtes_pkg::STEPS_W-1:0]   motor_steps,
	output logic signed [mtes_pkg::TURN_W-1:0]    turn_count,
	output logic [mtes_pkg::ANGLE_W-1:0]          raw_angle
);

	logic [mtes_pkg::MSTEP_W-1:0]         msteps_q;
	logic signed [mtes_pkg::STEPS_W-1:0]  offset_q;
	logic [mtes_pkg::ANGLE_W-1:0]         prev_angle_q;
	logic signed [mtes_pkg::TURN_W-1:0]   turns_q;
	logic                                 first_q;
	logic signed [mtes_pkg::PROD1_W-1:0]  prod1_s1;
	logic signed [mtes_pkg::PROD2_W-1:0]  prod2_s2;
	logic signed [mtes_pkg::STEPS_W-1:0]  steps_q;
	logic signed [mtes_pkg::TURN_W-1:0]   turn_out_q;
	logic [mtes_pkg::ANGLE_W-1:0]         angle_out_q;

	logic [mtes_pkg::ANGLE_W-1:0]         angle;
	logic signed [mtes_pkg::ANGLE_W:0]    diff;
	logic signed [mtes_pkg::TURN_W-1:0]   turns_d;
	logic signed [mtes_pkg::POS_W-1:0]    pos;
	logic signed [mtes_pkg::PROD2_W-1:0]  biased;
	logic signed [mtes_pkg::QUOT_W-1:0]   quot;
	logic signed [mtes_pkg::DIFF_W-1:0]   res;
	logic signed [mtes_pkg::STEPS_W-1:0]  res_sat;

	assign angle = {angle_high_byte[3:0] & mtes_pkg::ANGLE_HI_MASK, angle_low_byte};
	assign diff  = $signed({1'b0, angle}) - $signed({1'b0, prev_angle_q});

	always_comb begin
		turns_d = turns_q;
		if (diff < -mtes_pkg::HALF_TURN_COUNTS) begin
			if (turns_q != mtes_pkg::TURN_MAX) turns_d = turns_q + 24'sd1;
		end else if (diff > mtes_pkg::HALF_TURN_COUNTS) begin
			if (turns_q != mtes_pkg::TURN_MIN) turns_d = turns_q - 24'sd1;
		end
		if (first_q) turns_d = '0;
	end

	assign pos = $signed({turns_q, prev_angle_q});

	assign biased = prod2_s2 + (prod2_s2[mtes_pkg::PROD2_W-1] ? mtes_pkg::DIV_BIAS : '0);
	assign quot   = biased[mtes_pkg::PROD2_W-1:mtes_pkg::ANGLE_W];
	assign res    = mtes_pkg::DIFF_W'(quot) - mtes_pkg::DIFF_W'(offset_q);

	always_comb begin
		if (res[mtes_pkg::DIFF_W-1] != res[mtes_pkg::DIFF_W-2])
			res_sat = res[mtes_pkg::DIFF_W-1] ? mtes_pkg::STEPS_MIN : mtes_pkg::STEPS_MAX;
		else
			res_sat = res[mtes_pkg::STEPS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msteps_q     <= mtes_pkg::MSTEP_RESET;
			offset_q     <= '0;
			prev_angle_q <= '0;
			turns_q      <= '0;
			first_q      <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mtes_pkg::REG_MICROSTEPS: msteps_q <= cfg_data[mtes_pkg::MSTEP_W-1:0];
					mtes_pkg::REG_OFFSET:     offset_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.capture) begin
				prev_angle_q <= angle;
				turns_q      <= turns_d;
				first_q      <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) prod1_s1 <= pos * $signed({1'b0, msteps_q});
		if (cmd.scale) prod2_s2 <= mtes_pkg::PROD2_W'(prod1_s1) * mtes_pkg::MOTOR_STEPS;
		if (cmd.load_out) begin
			steps_q     <= res_sat;
			turn_out_q  <= turns_q;
			angle_out_q <= prev_angle_q;
		end
	end

	assign motor_steps = steps_q;
	assign turn_count  = turn_out_q;
	assign raw_angle   = angle_out_q;

endmodule
